### sv/erfc_pkg.sv
`timescale 1ns / 1ps
package erfc_pkg;

  localparam int unsigned DATAGRAM_LIMIT_DEF = 550;
  localparam int unsigned MAX_PAYLOAD_DEF    = 534;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // record overhead beyond the payload: length, number and CRC words
  localparam logic [16:0] REC_OVERHEAD = 17'd12;
  localparam logic [31:0] LEN_EXTRA    = 32'd4;
  localparam logic [15:0] FILL_MAX     = 16'hFFFF;

  typedef logic [4:0] slot_t;

  // byte slots of one item's output run
  localparam slot_t SLOT_HDR     = 5'd0;
  localparam slot_t SLOT_LEN     = 5'd4;
  localparam slot_t SLOT_NUM     = 5'd8;
  localparam slot_t SLOT_DATA    = 5'd12;
  localparam slot_t SLOT_CRC     = 5'd13;
  localparam slot_t SLOT_CRC_END = 5'd16;

endpackage

### sv/erfc_crc_byte.sv
`timescale 1ns / 1ps
module erfc_crc_byte import erfc_pkg::*; (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_out = c;
  end

endmodule

### sv/event_record_framer_crc32_core.sv
`timescale 1ns / 1ps
// Path: an item is held in the item register; its result bytes leave through the
// single output byte register, one result byte per cycle unless out_ready stalls.
// An item produces 1 byte for a mid-event payload byte, up to 17 when it opens a
// datagram; a dropped byte gives none. A new item is taken as the current one ends.
// Reset (rst, synchronous): no datagram open, CRC all ones, game tag zero.
module event_record_framer_crc32_core import erfc_pkg::*; #(
  parameter int unsigned DATAGRAM_LIMIT = DATAGRAM_LIMIT_DEF,
  parameter int unsigned MAX_PAYLOAD    = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        game_tag_we,
  input  logic [31:0] game_tag_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_of_event,
  input  logic        last_of_event,
  input  logic [9:0]  payload_length,
  input  logic [31:0] event_number,
  input  logic        batch_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        datagram_start,
  output logic        datagram_done,
  output logic        run_last
);

  logic [31:0] game_tag;

  // item register
  logic        item_valid;
  logic        item_fresh;
  slot_t       slot_q;
  logic [7:0]  data_q;
  logic        first_q;
  logic        last_q;
  logic [9:0]  plen_q;
  logic [31:0] number_q;
  logic        bend_q;

  // framing state
  logic [15:0] datagram_fill;
  logic        datagram_open;
  logic        event_active;
  logic [31:0] running_crc;

  logic        need_hdr;
  logic [16:0] fit_sum;
  slot_t       start_slot;
  slot_t       end_slot;
  slot_t       cur_slot;
  logic        drop;
  logic        out_adv;
  logic        emit;
  logic        item_done;
  logic        in_xfer;
  logic [31:0] len_word;
  logic [31:0] sel_word;
  logic [1:0]  lane;
  logic [7:0]  emit_byte;
  logic [31:0] crc_base;
  logic [31:0] crc_next;
  logic        crc_slot;

  assign fit_sum  = {1'b0, datagram_fill} + 17'(plen_q) + REC_OVERHEAD;
  assign need_hdr = !datagram_open || ({6'd0, plen_q} > 16'(MAX_PAYLOAD)) ||
                    (fit_sum > 17'(DATAGRAM_LIMIT));

  assign start_slot = !first_q ? SLOT_DATA : (need_hdr ? SLOT_HDR : SLOT_LEN);
  assign end_slot   = (last_q || bend_q) ? SLOT_CRC_END : SLOT_DATA;
  assign cur_slot   = item_fresh ? start_slot : slot_q;
  assign drop       = item_fresh && !first_q && !event_active;

  assign out_adv   = !out_valid || out_ready;
  assign emit      = item_valid && !drop && out_adv;
  assign item_done = item_valid && (drop || (out_adv && (cur_slot == end_slot)));
  assign in_ready  = !item_valid || item_done;
  assign in_xfer   = in_valid && in_ready;

  assign len_word = 32'(plen_q) + LEN_EXTRA;

  always_comb begin
    sel_word = game_tag;
    lane     = cur_slot[1:0];
    if (cur_slot >= SLOT_CRC) begin
      sel_word = running_crc ^ ALL_ONES;
      lane     = 2'(cur_slot - SLOT_CRC);
    end else if (cur_slot >= SLOT_NUM) begin
      sel_word = number_q;
    end else if (cur_slot >= SLOT_LEN) begin
      sel_word = len_word;
    end
    // big-endian: lane 0 is the top byte
    emit_byte = (cur_slot == SLOT_DATA) ? data_q : sel_word[{~lane, 3'b000} +: 8];
  end

  assign crc_slot = (cur_slot >= SLOT_LEN) && (cur_slot <= SLOT_DATA);
  assign crc_base = (cur_slot == SLOT_LEN) ? ALL_ONES : running_crc;

  erfc_crc_byte u_crc (
    .crc_in  (crc_base),
    .data    (emit_byte),
    .crc_out (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      game_tag <= '0;
    end else if (game_tag_we) begin
      game_tag <= game_tag_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item_fresh <= 1'b0;
      slot_q     <= SLOT_HDR;
    end else if (in_xfer) begin
      item_valid <= 1'b1;
      item_fresh <= 1'b1;
    end else if (item_done) begin
      item_valid <= 1'b0;
      item_fresh <= 1'b0;
    end else if (emit) begin
      item_fresh <= 1'b0;
      slot_q     <= cur_slot + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      data_q   <= data_byte;
      first_q  <= first_of_event;
      last_q   <= last_of_event;
      plen_q   <= payload_length;
      number_q <= event_number;
      bend_q   <= batch_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      datagram_fill <= '0;
      datagram_open <= 1'b0;
      event_active  <= 1'b0;
      running_crc   <= ALL_ONES;
    end else if (emit) begin
      if (cur_slot == SLOT_HDR) begin
        datagram_fill <= 16'd1;
        datagram_open <= 1'b1;
      end else if (datagram_fill != FILL_MAX) begin
        datagram_fill <= datagram_fill + 16'd1;
      end
      if (item_fresh && first_q) begin
        event_active <= 1'b1;
      end
      if (crc_slot) begin
        running_crc <= crc_next;
      end
      if (cur_slot == end_slot) begin
        if (last_q || bend_q) begin
          event_active <= 1'b0;
          running_crc  <= ALL_ONES;
        end
        // batch end closes the datagram
        if (bend_q) begin
          datagram_fill <= '0;
          datagram_open <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte       <= emit_byte;
      datagram_start <= (cur_slot == SLOT_HDR);
      datagram_done  <= bend_q && (cur_slot == end_slot);
      run_last       <= (cur_slot == end_slot);
    end
  end

  a_hdr_fill: assert property (@(posedge clk) disable iff (rst)
    (emit && cur_slot == SLOT_HDR) |=> (datagram_fill == 16'd1 && datagram_open))
    else $error("header byte did not restart datagram fill");

  a_mid_item_active: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_fresh) |-> event_active)
    else $error("item in progress without an active event");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (emit && bend_q && cur_slot == end_slot) |=> (!datagram_open && datagram_fill == 16'd0))
    else $error("batch end left datagram open");

endmodule
